@@ hdl/bsmg_pkg.sv @@
// ----------------------------------------------------------------------------
// bsmg_pkg: shared types and constants for the bounded set min/max gap block
// Field widths, the default store depth and the link between neighbor cells.
// ----------------------------------------------------------------------------
package bsmg_pkg;

  localparam int VAL_W           = 32;
  localparam int CAP_W           = 7;
  localparam int DEF_MAX_ENTRIES = 64;

  // What one cell shows to its right-hand neighbor.
  typedef struct packed {
    logic             live;   // a cell exists on this side
    logic             ins;    // the new value lands at or left of that cell
    logic [VAL_W-1:0] value;  // the value that cell holds
  } link_t;

endpackage

@@ hdl/bsmg_cell.sv @@
// ----------------------------------------------------------------------------
// bsmg_cell: one slot of the sorted store
// Compares the new value with its entry, shifts right on insertion and
// produces the gap candidate when it is the insertion slot.
// ----------------------------------------------------------------------------
module bsmg_cell (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        occupied,
  input  logic [bsmg_pkg::VAL_W-1:0]  new_value,
  input  bsmg_pkg::link_t             left,
  output bsmg_pkg::link_t             right,
  output logic [bsmg_pkg::VAL_W-1:0]  gap_cand
);
  import bsmg_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic [VAL_W-1:0] cand_r;
  logic [VAL_W-1:0] cand_nxt;
  logic             ins;
  logic             boundary;
  logic [VAL_W-1:0] gap_pred;
  logic [VAL_W-1:0] gap_succ;
  logic [VAL_W-1:0] best;

  // An empty slot always counts as an insertion point; equal values go after their equals.
  assign ins      = !occupied || ($signed(new_value) < $signed(val_r));
  assign boundary = ins && !left.ins;
  assign gap_pred = new_value - left.value;
  assign gap_succ = val_r - new_value;

  always_comb begin
    best = '1;
    if (left.live) begin
      best = gap_pred;
    end
    if (occupied && (gap_succ < best)) begin
      best = gap_succ;
    end
    cand_nxt = boundary ? best : '0;
    val_nxt  = val_r;
    if (ins) begin
      val_nxt = left.ins ? left.value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r  <= val_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign right.live  = 1'b1;
  assign right.ins   = ins;
  assign right.value = val_r;
  assign gap_cand    = cand_r;

endmodule

@@ hdl/bounded_set_min_max_gap.sv @@
// ----------------------------------------------------------------------------
// bounded_set_min_max_gap: bounded sorted set with shortest and longest span
// Inserts signed values into a row of sorted cells and reports the count,
// the smallest neighbor gap and the spread after every item.
// ----------------------------------------------------------------------------
// Each item runs through the states ST_CMP, ST_RED and ST_OUT: busy rises the
// cycle after start is taken and the result strobe out_valid is high for one
// cycle when the item leaves ST_OUT, in the first cycle that busy is low again,
// so a new start may be given in that same cycle. The steps are the parallel
// compare and shift in the cell row, the merge of the gap candidates of all
// cells, then the running minimum and the output register. The receiver cannot
// stall; every result must be taken in its strobe cycle. The capacity register
// may be written only while busy is low and no result is pending.
module bounded_set_min_max_gap #(
  parameter int MAX_ENTRIES = bsmg_pkg::DEF_MAX_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [bsmg_pkg::VAL_W-1:0] in_value,
  input  logic                        cfg_we,
  input  logic [bsmg_pkg::CAP_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output logic                        out_accepted,
  output logic [bsmg_pkg::CAP_W-1:0]  out_held_count,
  output logic                        out_enough,
  output logic [bsmg_pkg::VAL_W-1:0]  out_shortest_span,
  output logic [bsmg_pkg::VAL_W-1:0]  out_longest_span
);
  import bsmg_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_RED  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] min_gap_r, min_gap_nxt;
  logic [VAL_W-1:0] small_r, small_nxt;
  logic [VAL_W-1:0] large_r, large_nxt;
  logic [VAL_W-1:0] v_r;
  logic             acc_r;
  logic [VAL_W-1:0] gap_r, gap_nxt;
  logic             room;
  logic             load;
  logic             enough;

  logic             out_valid_r;
  logic             out_accepted_r;
  logic [CAP_W-1:0] out_held_count_r;
  logic             out_enough_r;
  logic [VAL_W-1:0] out_short_r;
  logic [VAL_W-1:0] out_long_r;

  link_t            link [MAX_ENTRIES+1];
  logic [VAL_W-1:0] cand [MAX_ENTRIES];

  assign busy = (state_r != ST_IDLE);
  assign room = (CMP_W'(cap_r) > CMP_W'(count_r)) && (count_r < CNT_W'(MAX_ENTRIES));
  assign load = (state_r == ST_CMP) && acc_r;

  // Cell row; the leftmost cell sees no neighbor and no predecessor.
  assign link[0].live  = 1'b0;
  assign link[0].ins   = 1'b0;
  assign link[0].value = '0;

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    logic occ;
    assign occ = (count_r > CNT_W'(gi));
    bsmg_cell u_cell (
      .clk       (clk),
      .load      (load),
      .occupied  (occ),
      .new_value (v_r),
      .left      (link[gi]),
      .right     (link[gi+1]),
      .gap_cand  (cand[gi])
    );
  end

  // Only the insertion slot holds a nonzero candidate, so an OR merges them.
  always_comb begin
    gap_nxt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gap_nxt = gap_nxt | cand[i];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    small_nxt   = small_r;
    large_nxt   = large_r;
    min_gap_nxt = min_gap_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (acc_r) begin
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0) begin
            small_nxt = v_r;
            large_nxt = v_r;
          end else begin
            if ($signed(v_r) < $signed(small_r)) begin
              small_nxt = v_r;
            end
            if ($signed(large_r) < $signed(v_r)) begin
              large_nxt = v_r;
            end
          end
        end
        state_nxt = ST_RED;
      end
      ST_RED: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (acc_r && (gap_r < min_gap_r)) begin
          min_gap_nxt = gap_r;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign enough = (count_r >= CNT_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= '0;
      count_r     <= '0;
      min_gap_r   <= '1;
      small_r     <= '0;
      large_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_gap_r   <= min_gap_nxt;
      small_r     <= small_nxt;
      large_r     <= large_nxt;
      out_valid_r <= (state_r == ST_OUT);
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      v_r   <= in_value;
      acc_r <= room;
    end
    if (state_r == ST_RED) begin
      gap_r <= gap_nxt;
    end
    if (state_r == ST_OUT) begin
      out_accepted_r   <= acc_r;
      out_held_count_r <= CAP_W'(count_r);
      out_enough_r     <= enough;
      out_short_r      <= enough ? min_gap_nxt : '0;
      out_long_r       <= enough ? (large_r - small_r) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_held_count    = out_held_count_r;
  assign out_enough        = out_enough_r;
  assign out_shortest_span = out_short_r;
  assign out_longest_span  = out_long_r;

endmodule
